// File: hdl/gjs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Gauss-Jordan solver.
// No dependencies.
package gjs_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CHK,
    ST_DIV_RD,
    ST_DIV_RUN,
    ST_ELF_RD,
    ST_EL_RD,
    ST_EL_MUL,
    ST_EL_WR,
    ST_BS_RD,
    ST_BS_MUL,
    ST_BS_WR,
    ST_OUT_RD,
    ST_OUT_HOLD
  } state_e;

  localparam int unsigned WordW = 32;

endpackage

// File: hdl/gauss_jordan_solver.sv
`timescale 1ns / 1ps
// Sequence: n*(n+1) load items, then a pivot check per pivot, n*(n+3)/2 serial
//   divisions in all, elimination of each element of the rows below the pivot, back
//   substitution, and one memory read per result.
// Throughput: one matrix at a time; the multiplications, the serial divider and the
//   one read port of the matrix memory set the cycle count. Loading takes one item per cycle.
// Reset: asynchronous, active low; clears the sequencer, load count and row count (2).
module gauss_jordan_solver #(
  parameter int MAX_ROWS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               element_value_valid_i,
  output logic               element_value_ready_o,
  input  logic signed [31:0] element_value_i,
  output logic               solution_valid_o,
  input  logic               solution_ready_i,
  output logic signed [31:0] solution_value_o,
  output logic [2:0]         solution_row_o,
  output logic               last_result_o,
  output logic               singular_o
);

  localparam int ColsMax = MAX_ROWS + 1;
  localparam int Depth   = MAX_ROWS * ColsMax;
  localparam int AW      = $clog2(Depth);
  localparam int RW      = $clog2(MAX_ROWS + 1);
  localparam int CW      = $clog2(ColsMax + 1);
  localparam int LW      = $clog2(Depth + 1);
  localparam int DW      = 32 + FRAC_BITS + 1;  // dividend magnitude width
  localparam int SW      = 66;                  // wide enough for any unsaturated result

  // Matrix memory: one write port, one registered read port.
  // Matrix memory holds no reset; every entry read is written by the load first.
  logic signed [31:0] mem_q [Depth];
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               we;
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [AW+CW:0] a;
    a = AW'(r) * (AW+CW+1)'(ColsMax) + (AW+CW+1)'(c);
    return a[AW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > SW'(signed'(33'sh0_7FFF_FFFF))) return 32'sh7FFF_FFFF;
    if (v < -SW'(signed'(34'sh0_8000_0000))) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Configuration and control state.
  logic [3:0]    rows_q;
  logic [RW-1:0] n_eff;
  logic [LW-1:0] total;
  logic [LW-1:0] load_cnt_q, load_cnt_d;
  logic [RW-1:0] lrow_q, lrow_d;
  logic [CW-1:0] lcol_q, lcol_d;

  always_comb begin
    if (rows_q == 4'd0) n_eff = RW'(1);
    else if (32'(rows_q) > MAX_ROWS) n_eff = RW'(MAX_ROWS);
    else n_eff = RW'(rows_q);
    total = LW'(32'(n_eff) * (32'(n_eff) + 1));
  end

  gjs_pkg::state_e state_q, state_d;
  logic [RW-1:0] i_q, i_d;     // pivot / back-substitution column
  logic [RW-1:0] k_q, k_d;     // target row
  logic [CW-1:0] z_q, z_d;     // column sweep
  logic signed [31:0] piv_q, piv_d;  // pivot, factor or s
  logic signed [31:0] e_q, e_d;      // element held across multiply
  logic signed [63:0] prod_q, prod_d;
  logic sing_q, sing_d;

  // Serial restoring divider, one quotient bit a cycle.
  logic [DW-1:0]  dq_q, dq_d;       // dividend shifting into quotient
  logic [32:0]    drem_q, drem_d;
  logic [32:0]    dden_q, dden_d;   // |divisor|
  logic           dneg_q, dneg_d;
  logic [6:0]     dcnt_q, dcnt_d;

  logic signed [SW-1:0] qmul_v;
  logic signed [SW-1:0] diff_v;
  logic signed [SW-1:0] diff_el_v;
  logic [33:0]          rem_sh;
  logic signed [SW-1:0] quo_v;

  always_comb begin
    qmul_v    = SW'(prod_q >>> FRAC_BITS);   // floor toward minus infinity
    rem_sh    = {drem_q, dq_q[DW-1]};
    // Back substitution saturates the product before subtracting; elimination does not.
    diff_v    = SW'(e_q) - SW'(sat32(qmul_v));
    diff_el_v = SW'(e_q) - qmul_v;
  end

  // Take the quotient with its last bit, as the final divider step completes.
  assign quo_v = dneg_q ? -SW'(signed'({1'b0, dq_d})) : SW'(signed'({1'b0, dq_d}));

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    lrow_d = lrow_q; lcol_d = lcol_q;
    i_d = i_q; k_d = k_q; z_d = z_q;
    piv_d = piv_q; e_d = e_q; prod_d = prod_q; sing_d = sing_q;
    dq_d = dq_q; drem_d = drem_q; dden_d = dden_q; dneg_d = dneg_q; dcnt_d = dcnt_q;
    case (state_q)
      gjs_pkg::ST_LOAD: begin
        if (element_value_valid_i) begin
          if (load_cnt_q + LW'(1) >= total) begin
            load_cnt_d = '0; lrow_d = '0; lcol_d = '0;
            i_d = '0; sing_d = 1'b0;
            state_d = gjs_pkg::ST_PIV_RD;
          end else begin
            load_cnt_d = load_cnt_q + LW'(1);
            if (lcol_q == CW'(n_eff)) begin
              lcol_d = '0; lrow_d = lrow_q + RW'(1);
            end else begin
              lcol_d = lcol_q + CW'(1);
            end
          end
        end
      end
      gjs_pkg::ST_PIV_RD: state_d = gjs_pkg::ST_PIV_CHK;
      gjs_pkg::ST_PIV_CHK: begin
        piv_d = rdata_q;
        z_d   = CW'(i_q);
        if (rdata_q == 32'sd0) begin
          sing_d = 1'b1;
          if (i_q + RW'(1) == n_eff) begin
            i_d = n_eff - RW'(1); state_d = gjs_pkg::ST_BS_RD; k_d = '0;
          end else begin
            i_d = i_q + RW'(1); state_d = gjs_pkg::ST_PIV_RD;
          end
        end else begin
          state_d = gjs_pkg::ST_DIV_RD;
        end
      end
      gjs_pkg::ST_DIV_RD: begin
        // rdata_q valid in the cycle after address issue; use a started flag via dcnt
        if (dcnt_q == 7'd0) begin
          dcnt_d = 7'd1;
        end else begin
          dneg_d = rdata_q[31] ^ piv_q[31];
          dq_d   = DW'({(rdata_q[31] ? 33'(-34'(rdata_q)) : 33'(rdata_q)),
                        {FRAC_BITS{1'b0}}});
          dden_d = piv_q[31] ? 33'(-34'(piv_q)) : 33'(piv_q);
          drem_d = '0;
          dcnt_d = 7'(DW);
          state_d = gjs_pkg::ST_DIV_RUN;
        end
      end
      gjs_pkg::ST_DIV_RUN: begin
        if (rem_sh >= {1'b0, dden_q}) begin
          drem_d = 33'(rem_sh - {1'b0, dden_q});
          dq_d   = {dq_q[DW-2:0], 1'b1};
        end else begin
          drem_d = rem_sh[32:0];
          dq_d   = {dq_q[DW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 7'd1;
        if (dcnt_q == 7'd1) begin
          dcnt_d = 7'd0;
          state_d = gjs_pkg::ST_DIV_RD;
          if (z_q == CW'(n_eff)) begin
            z_d = '0;
            k_d = i_q + RW'(1);
            state_d = (i_q + RW'(1) == n_eff) ? gjs_pkg::ST_BS_RD : gjs_pkg::ST_ELF_RD;
            if (i_q + RW'(1) == n_eff) k_d = '0;
          end else begin
            z_d = z_q + CW'(1);
          end
        end
      end
      gjs_pkg::ST_ELF_RD: begin
        if (dcnt_q == 7'd0) dcnt_d = 7'd1;
        else begin
          dcnt_d = 7'd0; piv_d = rdata_q; z_d = '0; state_d = gjs_pkg::ST_EL_RD;
        end
      end
      gjs_pkg::ST_EL_RD: begin
        // reads the pivot-row entry first, then the target entry
        if (dcnt_q == 7'd0) dcnt_d = 7'd1;
        else if (dcnt_q == 7'd1) begin
          dcnt_d = 7'd2; prod_d = 64'(piv_q) * 64'(rdata_q);
        end else begin
          dcnt_d = 7'd0; e_d = rdata_q; state_d = gjs_pkg::ST_EL_WR;
        end
      end
      gjs_pkg::ST_EL_WR: begin
        if (z_q == CW'(n_eff)) begin
          z_d = '0;
          if (k_q + RW'(1) == n_eff) begin
            if (i_q + RW'(1) == n_eff) begin
              i_d = n_eff - RW'(1); k_d = '0; state_d = gjs_pkg::ST_BS_RD;
            end else begin
              i_d = i_q + RW'(1); state_d = gjs_pkg::ST_PIV_RD;
            end
          end else begin
            k_d = k_q + RW'(1); state_d = gjs_pkg::ST_ELF_RD;
          end
        end else begin
          z_d = z_q + CW'(1); state_d = gjs_pkg::ST_EL_RD;
        end
      end
      gjs_pkg::ST_BS_RD: begin
        // read s = m[i][n], then m[k][i], then m[k][n]
        if (i_q == '0) begin
          k_d = '0; state_d = gjs_pkg::ST_OUT_RD;
        end else if (dcnt_q == 7'd0) dcnt_d = 7'd1;
        else if (dcnt_q == 7'd1) begin
          piv_d = rdata_q; dcnt_d = 7'd2;
        end else if (dcnt_q == 7'd2) dcnt_d = 7'd3;
        else if (dcnt_q == 7'd3) begin
          prod_d = 64'(rdata_q) * 64'(piv_q); dcnt_d = 7'd4;
        end else begin
          e_d = rdata_q; dcnt_d = 7'd2; state_d = gjs_pkg::ST_BS_WR;
        end
      end
      gjs_pkg::ST_BS_WR: begin
        state_d = gjs_pkg::ST_BS_RD;
        if (k_q + RW'(1) == i_q) begin
          k_d = '0; i_d = i_q - RW'(1); dcnt_d = 7'd0;
        end else begin
          k_d = k_q + RW'(1);
        end
      end
      gjs_pkg::ST_OUT_RD: begin
        if (dcnt_q == 7'd0) dcnt_d = 7'd1;
        else begin
          dcnt_d = 7'd0; e_d = rdata_q; state_d = gjs_pkg::ST_OUT_HOLD;
        end
      end
      gjs_pkg::ST_OUT_HOLD: begin
        if (solution_ready_i) begin
          if (k_q + RW'(1) == n_eff) state_d = gjs_pkg::ST_LOAD;
          else begin
            k_d = k_q + RW'(1); state_d = gjs_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_d = gjs_pkg::ST_LOAD;
    endcase
    if (cfg_we_i) begin
      load_cnt_d = '0; lrow_d = '0; lcol_d = '0;
    end
  end

  // Memory port drive.
  always_comb begin
    we = 1'b0; wdata = element_value_i; waddr = addr_of(lrow_q, lcol_q);
    raddr = addr_of(i_q, CW'(i_q));
    case (state_q)
      gjs_pkg::ST_LOAD: we = element_value_valid_i;
      gjs_pkg::ST_DIV_RD: raddr = addr_of(i_q, z_q);
      gjs_pkg::ST_DIV_RUN: begin
        raddr = addr_of(i_q, z_q);
        if (dcnt_q == 7'd1) begin
          we = 1'b1; waddr = addr_of(i_q, z_q); wdata = sat32(quo_v);
        end
      end
      gjs_pkg::ST_ELF_RD: raddr = addr_of(k_q, CW'(i_q));
      gjs_pkg::ST_EL_RD: raddr = (dcnt_q == 7'd0) ? addr_of(i_q, z_q) : addr_of(k_q, z_q);
      gjs_pkg::ST_EL_WR: begin
        we = 1'b1; waddr = addr_of(k_q, z_q); wdata = sat32(diff_el_v);
      end
      gjs_pkg::ST_BS_RD: begin
        if (dcnt_q == 7'd0) raddr = addr_of(i_q, CW'(n_eff));
        else if (dcnt_q == 7'd2) raddr = addr_of(k_q, CW'(i_q));
        else raddr = addr_of(k_q, CW'(n_eff));
      end
      gjs_pkg::ST_BS_WR: begin
        we = 1'b1; waddr = addr_of(k_q, CW'(n_eff)); wdata = sat32(diff_v);
      end
      gjs_pkg::ST_OUT_RD: raddr = addr_of(k_q, CW'(n_eff));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gjs_pkg::ST_LOAD;
      rows_q <= 4'd2;
      load_cnt_q <= '0; lrow_q <= '0; lcol_q <= '0;
      i_q <= '0; k_q <= '0; z_q <= '0; sing_q <= 1'b0; dcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) rows_q <= cfg_wdata_i;
      load_cnt_q <= load_cnt_d; lrow_q <= lrow_d; lcol_q <= lcol_d;
      i_q <= i_d; k_q <= k_d; z_q <= z_d; sing_q <= sing_d; dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d; e_q <= e_d; prod_q <= prod_d;
    dq_q <= dq_d; drem_q <= drem_d; dden_q <= dden_d; dneg_q <= dneg_d;
  end

  assign element_value_ready_o = (state_q == gjs_pkg::ST_LOAD);
  assign solution_valid_o      = (state_q == gjs_pkg::ST_OUT_HOLD);
  assign solution_value_o      = e_q;
  assign solution_row_o        = 3'(k_q);
  assign last_result_o         = (k_q + RW'(1) == n_eff);
  assign singular_o            = sing_q;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(element_value_ready_o && solution_valid_o))
    else $error("ready and result valid together");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    solution_valid_o && !solution_ready_i |=> solution_valid_o && $stable(solution_row_o))
    else $error("result dropped under stall");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    solution_valid_o |-> k_q < n_eff)
    else $error("result row out of range");
`endif

endmodule
